// File: rtl/vbsg_pkg.sv
package vbsg_pkg;

   // Width of the paint label carried from the start transaction to every result of its stroke.
   localparam int VALUE_BITS = 64;

   // Entries in the queue between the front end and the scan sequencer.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BRUSH_RADIUS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CIRCLE_SHAPE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLAT_MODE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIEW_PLANE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_X      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_Y      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT_Z      = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MERGE_TOOL   = 3'd7;

   // View planes: each one pins the axis normal to it in flat mode.
   localparam logic [1:0] VIEW_XY = 2'd0;
   localparam logic [1:0] VIEW_XZ = 2'd1;
   localparam logic [1:0] VIEW_YZ = 2'd2;

   // Request actions.
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   typedef struct packed {
      logic       circle_shape;
      logic       flat_mode;
      logic [1:0] view_plane;
      logic       merge_tool;
   } vbsg_mode_type;

   typedef struct packed {
      logic last;
      logic no_stroke;
   } vbsg_flags_type;

   // Queue entry layout: step flag, stroke-valid flag, low x/y/z, high x/y/z,
   // centre x/y/z and the paint label.
   function automatic int entry_bits(int coord_bits);
      return 2 + 9 * coord_bits + VALUE_BITS;
   endfunction

endpackage

// File: rtl/vbsg_req_if.sv
interface vbsg_req_if import vbsg_pkg::*; #(
   parameter int COORD_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [COORD_BITS-1:0] centre_x;
   logic [COORD_BITS-1:0] centre_y;
   logic [COORD_BITS-1:0] centre_z;
   logic [VALUE_BITS-1:0] paint_value;

   modport source (
      output valid, action, centre_x, centre_y, centre_z, paint_value,
      input  ready
   );

   modport sink (
      input  valid, action, centre_x, centre_y, centre_z, paint_value,
      output ready
   );
endinterface

// File: rtl/vbsg_rsp_if.sv
interface vbsg_rsp_if import vbsg_pkg::*; #(
   parameter int COORD_BITS = 16
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] voxel_x;
   logic [COORD_BITS-1:0] voxel_y;
   logic [COORD_BITS-1:0] voxel_z;
   logic [VALUE_BITS-1:0] write_value;
   logic                  do_write;
   logic                  last;
   logic                  no_stroke;

   modport source (
      output valid, voxel_x, voxel_y, voxel_z, write_value, do_write, last, no_stroke,
      input  ready
   );

   modport sink (
      input  valid, voxel_x, voxel_y, voxel_z, write_value, do_write, last, no_stroke,
      output ready
   );
endinterface

// File: rtl/vbsg_front.sv
module vbsg_front import vbsg_pkg::*; #(
   parameter int COORD_BITS  = 16,
   parameter int RADIUS_BITS = 8
) (
   vbsg_req_if.sink                              req,
   input  logic                                  queue_full,
   input  vbsg_mode_type                         mode,
   input  logic [RADIUS_BITS-1:0]                radius,
   input  logic [COORD_BITS-1:0]                 limit_x,
   input  logic [COORD_BITS-1:0]                 limit_y,
   input  logic [COORD_BITS-1:0]                 limit_z,
   output logic                                  push,
   output logic [entry_bits(COORD_BITS)-1:0]     entry
);

   localparam int SUM_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 1;

   logic [2:0][COORD_BITS-1:0] cen;
   logic [2:0][COORD_BITS-1:0] lim;
   logic [2:0][COORD_BITS-1:0] lo;
   logic [2:0][COORD_BITS-1:0] hi;
   logic [SUM_BITS-1:0]        c_ext;
   logic [SUM_BITS-1:0]        r_ext;
   logic [SUM_BITS-1:0]        h_sum;
   logic                       box_ok;
   logic                       stroke_ok;

   always_comb begin
      cen[0] = req.centre_x;
      cen[1] = req.centre_y;
      cen[2] = req.centre_z;
      lim[0] = limit_x;
      lim[1] = limit_y;
      lim[2] = limit_z;
      c_ext  = '0;
      h_sum  = '0;
      r_ext  = SUM_BITS'(radius);
      // The three axes are independent: clamp centre -/+ radius to 0 and the limit.
      for (int a = 0; a < 3; a++) begin
         c_ext = SUM_BITS'(cen[a]);
         h_sum = c_ext + r_ext;
         lo[a] = (c_ext > r_ext) ? COORD_BITS'(c_ext - r_ext) : '0;
         hi[a] = (h_sum < SUM_BITS'(lim[a])) ? COORD_BITS'(h_sum) : lim[a];
      end
      // A pinned axis takes the centre as it is, without clamping.
      if (mode.flat_mode) begin
         case (mode.view_plane)
            VIEW_XY: begin
               lo[2] = cen[2];
               hi[2] = cen[2];
            end
            VIEW_XZ: begin
               lo[1] = cen[1];
               hi[1] = cen[1];
            end
            VIEW_YZ: begin
               lo[0] = cen[0];
               hi[0] = cen[0];
            end
            default: begin
            end
         endcase
      end
      box_ok    = (lo[0] <= hi[0]) && (lo[1] <= hi[1]) && (lo[2] <= hi[2]);
      stroke_ok = box_ok && !mode.merge_tool;
   end

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;
   assign entry     = {req.action == ACTION_STEP, stroke_ok,
                       lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                       cen[0], cen[1], cen[2], req.paint_value};

endmodule

// File: rtl/vbsg_queue.sv
module vbsg_queue import vbsg_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/vbsg_scan.sv
module vbsg_scan import vbsg_pkg::*; #(
   parameter int COORD_BITS  = 16,
   parameter int RADIUS_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  queue_empty,
   input  logic [entry_bits(COORD_BITS)-1:0]     head,
   output logic                                  pop,
   input  logic                                  s1_ready,
   output logic                                  s1_valid,
   output logic [COORD_BITS-1:0]                 s1_x,
   output logic [COORD_BITS-1:0]                 s1_y,
   output logic [COORD_BITS-1:0]                 s1_z,
   output logic [VALUE_BITS-1:0]                 s1_value,
   output logic [((RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] s1_dx,
   output logic [((RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] s1_dy,
   output logic [((RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] s1_dz,
   output vbsg_flags_type                        s1_flags
);

   // Inside the box no coordinate is further than the radius from the centre.
   localparam int DIFF_BITS = (RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic                  head_step, head_ok;
   logic [COORD_BITS-1:0] head_lo_x, head_lo_y, head_lo_z;
   logic [COORD_BITS-1:0] head_hi_x, head_hi_y, head_hi_z;
   logic [COORD_BITS-1:0] head_c_x, head_c_y, head_c_z;
   logic [VALUE_BITS-1:0] head_value;

   logic                  active_ff, active_in;
   logic [COORD_BITS-1:0] scan_x_ff, scan_x_in, scan_y_ff, scan_y_in, scan_z_ff, scan_z_in;
   logic [COORD_BITS-1:0] low_y_ff, low_y_in, low_z_ff, low_z_in;
   logic [COORD_BITS-1:0] high_x_ff, high_x_in, high_y_ff, high_y_in, high_z_ff, high_z_in;
   logic [COORD_BITS-1:0] cen_x_ff, cen_x_in, cen_y_ff, cen_y_in, cen_z_ff, cen_z_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [COORD_BITS-1:0] s1_x_ff, s1_x_in, s1_y_ff, s1_y_in, s1_z_ff, s1_z_in;
   logic [VALUE_BITS-1:0] s1_value_ff, s1_value_in;
   logic [DIFF_BITS-1:0]  s1_dx_ff, s1_dx_in, s1_dy_ff, s1_dy_in, s1_dz_ff, s1_dz_in;
   vbsg_flags_type        s1_flags_ff, s1_flags_in;

   logic s1_en, pop_start, pop_step, at_end;

   assign {head_step, head_ok, head_lo_x, head_lo_y, head_lo_z,
           head_hi_x, head_hi_y, head_hi_z, head_c_x, head_c_y, head_c_z, head_value} = head;

   assign s1_en     = !s1_valid_ff || s1_ready;
   assign pop_start = !queue_empty && !head_step;
   assign pop_step  = !queue_empty && head_step && s1_en;
   assign pop       = pop_start || pop_step;
   assign at_end    = (scan_x_ff == high_x_ff) && (scan_y_ff == high_y_ff) &&
                      (scan_z_ff == high_z_ff);

   always_comb begin
      active_in = active_ff;
      scan_x_in = scan_x_ff;
      scan_y_in = scan_y_ff;
      scan_z_in = scan_z_ff;
      low_y_in  = low_y_ff;
      low_z_in  = low_z_ff;
      high_x_in = high_x_ff;
      high_y_in = high_y_ff;
      high_z_in = high_z_ff;
      cen_x_in  = cen_x_ff;
      cen_y_in  = cen_y_ff;
      cen_z_in  = cen_z_ff;
      value_in  = value_ff;

      if (pop_start) begin
         active_in = head_ok;
         scan_x_in = head_lo_x;
         scan_y_in = head_lo_y;
         scan_z_in = head_lo_z;
         low_y_in  = head_lo_y;
         low_z_in  = head_lo_z;
         high_x_in = head_hi_x;
         high_y_in = head_hi_y;
         high_z_in = head_hi_z;
         cen_x_in  = head_c_x;
         cen_y_in  = head_c_y;
         cen_z_in  = head_c_z;
         value_in  = head_value;
      end else if (pop_step && active_ff) begin
         // Odometer over the box: z fastest, then y, then x.
         if (at_end) begin
            active_in = 1'b0;
         end else if (scan_z_ff != high_z_ff) begin
            scan_z_in = scan_z_ff + COORD_BITS'(1);
         end else begin
            scan_z_in = low_z_ff;
            if (scan_y_ff != high_y_ff) begin
               scan_y_in = scan_y_ff + COORD_BITS'(1);
            end else begin
               scan_y_in = low_y_ff;
               scan_x_in = scan_x_ff + COORD_BITS'(1);
            end
         end
      end

      s1_valid_in = s1_en ? pop_step : s1_valid_ff;
      s1_x_in     = s1_x_ff;
      s1_y_in     = s1_y_ff;
      s1_z_in     = s1_z_ff;
      s1_value_in = s1_value_ff;
      s1_dx_in    = s1_dx_ff;
      s1_dy_in    = s1_dy_ff;
      s1_dz_in    = s1_dz_ff;
      s1_flags_in = s1_flags_ff;
      if (pop_step) begin
         if (active_ff) begin
            s1_x_in               = scan_x_ff;
            s1_y_in               = scan_y_ff;
            s1_z_in               = scan_z_ff;
            s1_value_in           = value_ff;
            s1_dx_in              = DIFF_BITS'(abs_diff(scan_x_ff, cen_x_ff));
            s1_dy_in              = DIFF_BITS'(abs_diff(scan_y_ff, cen_y_ff));
            s1_dz_in              = DIFF_BITS'(abs_diff(scan_z_ff, cen_z_ff));
            s1_flags_in.last      = at_end;
            s1_flags_in.no_stroke = 1'b0;
         end else begin
            s1_x_in               = '0;
            s1_y_in               = '0;
            s1_z_in               = '0;
            s1_value_in           = '0;
            s1_dx_in              = '0;
            s1_dy_in              = '0;
            s1_dz_in              = '0;
            s1_flags_in.last      = 1'b0;
            s1_flags_in.no_stroke = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_x_ff   <= scan_x_in;
      scan_y_ff   <= scan_y_in;
      scan_z_ff   <= scan_z_in;
      low_y_ff    <= low_y_in;
      low_z_ff    <= low_z_in;
      high_x_ff   <= high_x_in;
      high_y_ff   <= high_y_in;
      high_z_ff   <= high_z_in;
      cen_x_ff    <= cen_x_in;
      cen_y_ff    <= cen_y_in;
      cen_z_ff    <= cen_z_in;
      value_ff    <= value_in;
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      s1_z_ff     <= s1_z_in;
      s1_value_ff <= s1_value_in;
      s1_dx_ff    <= s1_dx_in;
      s1_dy_ff    <= s1_dy_in;
      s1_dz_ff    <= s1_dz_in;
      s1_flags_ff <= s1_flags_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_x     = s1_x_ff;
   assign s1_y     = s1_y_ff;
   assign s1_z     = s1_z_ff;
   assign s1_value = s1_value_ff;
   assign s1_dx    = s1_dx_ff;
   assign s1_dy    = s1_dy_ff;
   assign s1_dz    = s1_dz_ff;
   assign s1_flags = s1_flags_ff;

endmodule

// File: rtl/vbsg_shape.sv
module vbsg_shape import vbsg_pkg::*; #(
   parameter int COORD_BITS  = 16,
   parameter int RADIUS_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RADIUS_BITS-1:0] radius,
   input  vbsg_mode_type          mode,
   input  logic                   s1_valid,
   output logic                   s1_ready,
   input  logic [COORD_BITS-1:0]  s1_x,
   input  logic [COORD_BITS-1:0]  s1_y,
   input  logic [COORD_BITS-1:0]  s1_z,
   input  logic [VALUE_BITS-1:0]  s1_value,
   input  logic [((RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] s1_dx,
   input  logic [((RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] s1_dy,
   input  logic [((RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS)-1:0] s1_dz,
   input  vbsg_flags_type         s1_flags,
   vbsg_rsp_if.source             rsp
);

   localparam int DIFF_BITS = (RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS;
   localparam int SQ_BITS   = 2 * DIFF_BITS;
   localparam int LIM_BITS  = 2 * RADIUS_BITS + 2;

   logic [LIM_BITS-1:0]   rp1;
   logic [LIM_BITS-1:0]   lim_ff;
   logic [LIM_BITS-1:0]   dist_sum;

   logic                  s2_valid_ff, s2_valid_in;
   logic [COORD_BITS-1:0] s2_x_ff, s2_y_ff, s2_z_ff;
   logic [VALUE_BITS-1:0] s2_value_ff;
   logic [SQ_BITS-1:0]    s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   vbsg_flags_type        s2_flags_ff;

   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [VALUE_BITS-1:0] out_value_ff;
   logic                  out_write_ff, out_write_in;
   vbsg_flags_type        out_flags_ff;

   logic out_en, s2_en;

   assign out_en   = !out_valid_ff || rsp.ready;
   assign s2_en    = !s2_valid_ff || out_en;
   assign s1_ready = s2_en;

   // Squared radius bound (r+1)^2, refreshed from the register every cycle.
   assign rp1 = LIM_BITS'(radius) + LIM_BITS'(1);

   always_ff @(posedge clock) begin
      lim_ff <= rp1 * rp1;
   end

   assign dist_sum     = LIM_BITS'(s2_sqx_ff) + LIM_BITS'(s2_sqy_ff) + LIM_BITS'(s2_sqz_ff);
   assign out_write_in = !s2_flags_ff.no_stroke && (!mode.circle_shape || (dist_sum < lim_ff));
   assign s2_valid_in  = s2_en ? s1_valid : s2_valid_ff;
   assign out_valid_in = out_en ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_x_ff     <= s1_x;
         s2_y_ff     <= s1_y;
         s2_z_ff     <= s1_z;
         s2_value_ff <= s1_value;
         s2_sqx_ff   <= SQ_BITS'(s1_dx) * SQ_BITS'(s1_dx);
         s2_sqy_ff   <= SQ_BITS'(s1_dy) * SQ_BITS'(s1_dy);
         s2_sqz_ff   <= SQ_BITS'(s1_dz) * SQ_BITS'(s1_dz);
         s2_flags_ff <= s1_flags;
      end
      if (out_en) begin
         out_x_ff     <= s2_x_ff;
         out_y_ff     <= s2_y_ff;
         out_z_ff     <= s2_z_ff;
         out_value_ff <= s2_value_ff;
         out_write_ff <= out_write_in;
         out_flags_ff <= s2_flags_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.voxel_x     = out_x_ff;
   assign rsp.voxel_y     = out_y_ff;
   assign rsp.voxel_z     = out_z_ff;
   assign rsp.write_value = out_value_ff;
   assign rsp.do_write    = out_write_ff;
   assign rsp.last        = out_flags_ff.last;
   assign rsp.no_stroke   = out_flags_ff.no_stroke;

endmodule

// File: rtl/voxel_brush_scan_generator.sv
// Channel    Direction  Handshake      Carries
// req_chan   in         valid/ready    action, centre_x/y/z, paint_value
// rsp_chan   out        valid/ready    voxel_x/y/z, write_value, do_write, last, no_stroke
// csr_*      in         write enable   register index and data, no read-back
//
// One request transaction is taken every cycle while the four-entry queue has room; the
// scan sequencer retires one step per cycle while the output is not stalled, so the
// sustained rate is one transaction per cycle. A step's request is written into a queue
// entry, and its result then passes the scan register, the square register and the
// output register in that order.
// Reset is synchronous and active high; it empties the queue and every pipeline stage and
// drops any stroke. A stalled response stalls the square and scan stages behind it, and
// requests keep entering until the queue is full.
module voxel_brush_scan_generator import vbsg_pkg::*; #(
   parameter int COORD_BITS  = 16,
   parameter int RADIUS_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   vbsg_req_if.sink                    req_chan,
   vbsg_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] csr_data
);

   localparam int ENTRY_BITS = entry_bits(COORD_BITS);
   localparam int DIFF_BITS  = (RADIUS_BITS < COORD_BITS) ? RADIUS_BITS : COORD_BITS;

   // Configuration registers, read directly by every stage. The user must change them only
   // while no transaction is in flight; the block itself does not enforce this.
   logic [RADIUS_BITS-1:0] radius_ff;
   logic [COORD_BITS-1:0]  limit_x_ff, limit_y_ff, limit_z_ff;
   vbsg_mode_type          mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= '0;
         limit_x_ff <= '1;
         limit_y_ff <= '1;
         limit_z_ff <= '1;
         mode_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BRUSH_RADIUS: radius_ff             <= RADIUS_BITS'(csr_data);
            CSR_CIRCLE_SHAPE: mode_ff.circle_shape  <= csr_data[0];
            CSR_FLAT_MODE:    mode_ff.flat_mode     <= csr_data[0];
            CSR_VIEW_PLANE:   mode_ff.view_plane    <= csr_data[1:0];
            CSR_LIMIT_X:      limit_x_ff            <= COORD_BITS'(csr_data);
            CSR_LIMIT_Y:      limit_y_ff            <= COORD_BITS'(csr_data);
            CSR_LIMIT_Z:      limit_z_ff            <= COORD_BITS'(csr_data);
            CSR_MERGE_TOOL:   mode_ff.merge_tool    <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each transaction and, for a start, works out the clamped
   // bounding box before it enters the queue.
   logic                  push, queue_full, queue_empty, pop;
   logic [ENTRY_BITS-1:0] entry, head;

   vbsg_front #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .req        (req_chan),
      .queue_full (queue_full),
      .mode       (mode_ff),
      .radius     (radius_ff),
      .limit_x    (limit_x_ff),
      .limit_y    (limit_y_ff),
      .limit_z    (limit_z_ff),
      .push       (push),
      .entry      (entry)
   );

   vbsg_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   // The back end: the scan sequencer owns the stroke state and walks the box; a start
   // entry is consumed at once, a step entry only when the next stage can take it.
   logic                  s1_valid, s1_ready;
   logic [COORD_BITS-1:0] s1_x, s1_y, s1_z;
   logic [VALUE_BITS-1:0] s1_value;
   logic [DIFF_BITS-1:0]  s1_dx, s1_dy, s1_dz;
   vbsg_flags_type        s1_flags;

   vbsg_scan #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .s1_ready    (s1_ready),
      .s1_valid    (s1_valid),
      .s1_x        (s1_x),
      .s1_y        (s1_y),
      .s1_z        (s1_z),
      .s1_value    (s1_value),
      .s1_dx       (s1_dx),
      .s1_dy       (s1_dy),
      .s1_dz       (s1_dz),
      .s1_flags    (s1_flags)
   );

   // Sphere test, used when circle_shape is set: squares are registered, then summed and
   // compared against (r+1)^2 in front of the output register.
   vbsg_shape #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_shape (
      .clock    (clock),
      .reset    (reset),
      .radius   (radius_ff),
      .mode     (mode_ff),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_x     (s1_x),
      .s1_y     (s1_y),
      .s1_z     (s1_z),
      .s1_value (s1_value),
      .s1_dx    (s1_dx),
      .s1_dy    (s1_dy),
      .s1_dz    (s1_dz),
      .s1_flags (s1_flags),
      .rsp      (rsp_chan)
   );

endmodule
